[design/ipru_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ipru_pkg
// Shared types and codes of the integer pixel replication upscaler.
// ----------------------------------------------------------------------------
package ipru_pkg;

	localparam int PIX_W   = 24;
	localparam int CFG_W   = 13;
	localparam int CFG_IDX_W = 2;

	localparam int SCALE_REG_W  = 7;
	localparam int WIDTH_REG_W  = 11;
	localparam int HEIGHT_REG_W = 13;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

	// item operations
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_EMIT = 1'b1;

	typedef enum logic [1:0] {
		KIND_LOAD  = 2'd0,
		KIND_PIXEL = 2'd1,
		KIND_PAD   = 2'd2,
		KIND_ERR   = 2'd3
	} kind_t;

	typedef enum logic {
		PH_LOAD = 1'b0,
		PH_EMIT = 1'b1
	} phase_t;

	typedef struct packed {
		logic             op;
		logic [PIX_W-1:0] pixel_in;
	} in_item_t;

	typedef struct packed {
		kind_t            kind;
		logic [PIX_W-1:0] pixel_out;
		logic             last_in_line;
		logic             last_in_image;
	} out_item_t;

	// per-item decision of the sequencer
	typedef struct packed {
		kind_t kind;
		logic  line_end;
		logic  image_end;
	} step_t;

endpackage

`default_nettype wire

[design/ipru_stream_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ipru_stream_if
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface ipru_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[design/ipru_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ipru_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ipru_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[design/ipru_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ipru_ctrl
// Load/emit sequencer: position counters, line store addressing, marks.
// ----------------------------------------------------------------------------
module ipru_ctrl #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_SCALE = 100,
	parameter int MAX_ROWS  = 4096,
	localparam int CW = $clog2(MAX_WIDTH + 1),
	localparam int SW = $clog2(MAX_SCALE + 1),
	localparam int RW = $clog2(MAX_ROWS + 1),
	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            accept,
	input  wire logic            op,
	input  wire logic [SW-1:0]   scale,
	input  wire logic [CW-1:0]   width,
	input  wire logic [RW-1:0]   height,
	output ipru_pkg::step_t      step,
	output logic                 wr_en,
	output logic      [AW-1:0]   wr_addr,
	output logic                 rd_en,
	output logic      [AW-1:0]   rd_addr
);
	import ipru_pkg::*;

	phase_t        phase_q, phase_d;
	logic [CW-1:0] load_q, load_d;
	logic [CW-1:0] col_q, col_d;
	logic [SW-1:0] rep_q, rep_d;
	logic [1:0]    padc_q, padc_d;
	logic [SW-1:0] lrep_q, lrep_d;
	logic [RW-1:0] row_q, row_d;

	logic [1:0]    pad;
	logic [1:0]    wlo, slo;
	logic [CW-1:0] load_inc, col_inc;
	logic [SW-1:0] rep_inc, lrep_inc;
	logic [RW-1:0] row_inc;
	logic [1:0]    padc_inc;

	// (w * s) mod 4 needs only the low two bits of each factor
	assign wlo = 2'(32'(width));
	assign slo = 2'(32'(scale));
	assign pad = wlo * slo;

	assign load_inc = load_q + CW'(1);
	assign col_inc  = col_q + CW'(1);
	assign rep_inc  = rep_q + SW'(1);
	assign lrep_inc = lrep_q + SW'(1);
	assign row_inc  = row_q + RW'(1);
	assign padc_inc = padc_q + 2'd1;

	assign wr_addr = load_q[AW-1:0];
	assign rd_addr = col_q[AW-1:0];

	always_comb begin
		phase_d = phase_q;
		load_d  = load_q;
		col_d   = col_q;
		rep_d   = rep_q;
		padc_d  = padc_q;
		lrep_d  = lrep_q;
		row_d   = row_q;
		step.kind      = KIND_ERR;
		step.line_end  = 1'b0;
		step.image_end = 1'b0;
		wr_en = 1'b0;
		rd_en = 1'b0;

		if ((op == OP_LOAD) == (phase_q == PH_EMIT)) begin
			step.kind = KIND_ERR;
		end else if (op == OP_LOAD) begin
			step.kind = KIND_LOAD;
			wr_en  = accept && (32'(load_q) < MAX_WIDTH);
			load_d = load_inc;
			if (load_inc >= width) begin
				load_d  = '0;
				col_d   = '0;
				rep_d   = '0;
				padc_d  = '0;
				lrep_d  = '0;
				phase_d = PH_EMIT;
			end
		end else begin
			if (col_q < width) begin
				step.kind = KIND_PIXEL;
				rd_en = accept;
				rep_d = rep_inc;
				if (rep_inc >= scale) begin
					rep_d = '0;
					col_d = col_inc;
					step.line_end = (col_inc >= width) && (pad == 2'd0);
				end
			end else begin
				step.kind = KIND_PAD;
				padc_d = padc_inc;
				step.line_end = (padc_inc >= pad);
			end
			if (step.line_end) begin
				col_d  = '0;
				rep_d  = '0;
				padc_d = '0;
				lrep_d = lrep_inc;
				if (lrep_inc >= scale) begin
					lrep_d  = '0;
					phase_d = PH_LOAD;
					row_d   = row_inc;
					if (row_inc >= height) begin
						row_d = '0;
						step.image_end = 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LOAD;
			load_q  <= '0;
			col_q   <= '0;
			rep_q   <= '0;
			padc_q  <= '0;
			lrep_q  <= '0;
			row_q   <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			load_q  <= load_d;
			col_q   <= col_d;
			rep_q   <= rep_d;
			padc_q  <= padc_d;
			lrep_q  <= lrep_d;
			row_q   <= row_d;
		end
	end

endmodule

`default_nettype wire

[design/integer_pixel_replication_upscaler.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// integer_pixel_replication_upscaler
// Nearest-neighbor integer upscaler for 24-bit pixels with a line buffer.
// ----------------------------------------------------------------------------
// One source row is loaded pixel by pixel into a line buffer RAM (load items),
// then every emit item returns the next output unit: each pixel repeated scale
// times, zero padding bytes up to a 4-byte line boundary, the whole line sent
// scale times, with last-in-line and last-in-image marks. One item is taken
// every clock unless stalled; its result appears in the output register in the
// cycle after the transfer, which is the registered read of the line buffer
// RAM. The line buffer needs no clearing pass after reset. Register values of
// zero act as one, values above the maximums as the maximum, clamped on write.
// Registers must be written only while no result is outstanding (unenforced).
// ----------------------------------------------------------------------------
module integer_pixel_replication_upscaler #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_SCALE = 100,
	parameter int MAX_ROWS  = 4096
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [ipru_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [ipru_pkg::CFG_W-1:0]      cfg_wdata,
	ipru_stream_if.sink                          in_ch,
	ipru_stream_if.source                        out_ch
);
	import ipru_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH + 1);
	localparam int SW = $clog2(MAX_SCALE + 1);
	localparam int RW = $clog2(MAX_ROWS + 1);
	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

	// clamped configuration
	logic [SW-1:0] scale_q;
	logic [CW-1:0] width_q;
	logic [RW-1:0] height_q;

	logic [SCALE_REG_W-1:0]  wr_scale;
	logic [WIDTH_REG_W-1:0]  wr_width;
	logic [HEIGHT_REG_W-1:0] wr_height;

	assign wr_scale  = cfg_wdata[SCALE_REG_W-1:0];
	assign wr_width  = cfg_wdata[WIDTH_REG_W-1:0];
	assign wr_height = cfg_wdata[HEIGHT_REG_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q  <= SW'(1);
			width_q  <= CW'(1);
			height_q <= RW'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SCALE: begin
					if (wr_scale == '0) scale_q <= SW'(1);
					else if (32'(wr_scale) > MAX_SCALE) scale_q <= SW'(MAX_SCALE);
					else scale_q <= SW'(wr_scale);
				end
				REG_WIDTH: begin
					if (wr_width == '0) width_q <= CW'(1);
					else if (32'(wr_width) > MAX_WIDTH) width_q <= CW'(MAX_WIDTH);
					else width_q <= CW'(wr_width);
				end
				REG_HEIGHT: begin
					if (wr_height == '0) height_q <= RW'(1);
					else if (32'(wr_height) > MAX_ROWS) height_q <= RW'(MAX_ROWS);
					else height_q <= RW'(wr_height);
				end
				default: begin
				end
			endcase
		end
	end

	// handshake: the output register frees up in the same cycle it is taken
	logic  valid_s1;
	step_t step_s1;
	logic  accept;

	assign in_ch.ready = !valid_s1 || out_ch.ready;
	assign accept      = in_ch.valid && in_ch.ready;

	// sequencer and line buffer
	step_t             step;
	logic              wr_en, rd_en;
	logic [AW-1:0]     wr_addr, rd_addr;
	logic [PIX_W-1:0]  rd_data;

	ipru_ctrl #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_SCALE (MAX_SCALE),
		.MAX_ROWS  (MAX_ROWS)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.op      (in_ch.data.op),
		.scale   (scale_q),
		.width   (width_q),
		.height  (height_q),
		.step    (step),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.rd_en   (rd_en),
		.rd_addr (rd_addr)
	);

	// read data only moves on a pixel transfer, so it holds while stalled
	ipru_ram #(
		.WIDTH (PIX_W),
		.DEPTH (MAX_WIDTH)
	) u_line_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (in_ch.data.pixel_in),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			step_s1 <= step;
		end
	end

	assign out_ch.valid              = valid_s1;
	assign out_ch.data.kind          = step_s1.kind;
	assign out_ch.data.pixel_out     = (step_s1.kind == KIND_PIXEL) ? rd_data : '0;
	assign out_ch.data.last_in_line  = step_s1.line_end;
	assign out_ch.data.last_in_image = step_s1.image_end;

endmodule

`default_nettype wire
